[rtl/sml_pkg.sv]
// Shared types for the subnet membership table: action codes, request and
// response transfers, and the stored entry layout. No dependencies.
`default_nettype none

package sml_pkg;

  // Action codes carried in a request
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PLEN_W = 6;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   address;
    logic [PLEN_W-1:0]   prefix_len;
  } req_t;

  typedef struct packed {
    logic is_protected;
    logic accepted;
  } rsp_t;

  // One table entry: network word and prefix length
  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [PLEN_W-1:0] plen;
  } entry_t;

endpackage

`default_nettype wire

[rtl/subnet_membership_match.sv]
// Subnet membership table: append, clear and first-match lookup over a
// table memory scanned by one shared compare unit. Uses sml_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------
//   req     | in        | req_valid, req_stall | sml_pkg::req_t
//   rsp     | out       | rsp_valid, rsp_stall | sml_pkg::rsp_t
//
// Clear, append and unknown actions load the registered response in the cycle after the request transfers.
// A lookup reads one entry per cycle through the table's read port and
// compares it in the next cycle; a lookup on an empty table skips the scan.
// A hit ends the scan early.
// Reset empties the table by zeroing the entry count; entries are not cleared.
// req_stall is high during a scan and while a response is held by rsp_stall.
`default_nettype none

module subnet_membership_match #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sml_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sml_pkg::rsp_t      rsp
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           scan_idx;
  logic                       rd_valid;
  logic [sml_pkg::ADDR_W-1:0] query;
  sml_pkg::entry_t            rd_entry;
  sml_pkg::entry_t            table_mem [MAX_ENTRIES];

  logic                       req_xfer;
  logic                       wr_en;
  logic                       issue;
  logic [sml_pkg::ADDR_W-1:0] mask;
  logic                       hit;
  logic                       rsp_load;

  // Take a request only when idle and the response slot frees this cycle
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign req_xfer  = req_valid && !req_stall;
  assign wr_en     = req_xfer && (req.action == sml_pkg::ACT_APPEND) && (count < CNT_MAX);
  assign issue     = (state == S_SCAN) && (scan_idx < count);

  // Load the response register when an action finishes
  assign rsp_load = (req_xfer && !((req.action == sml_pkg::ACT_LOOKUP) && (count != '0)))
                    || ((state == S_SCAN) && (hit || !issue));

  // Prefix mask: zero and anything from 32 up select the full word
  always_comb begin
    if ((rd_entry.plen == '0) || (rd_entry.plen >= sml_pkg::PLEN_W'(32))) begin
      mask = '1;
    end else begin
      mask = (32'd1 << rd_entry.plen[4:0]) - 32'd1;
    end
  end

  // Shared compare unit on the entry read last cycle
  assign hit = rd_valid && ((rd_entry.net & mask) == (query & mask));

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[count[IDX_W-1:0]] <= '{net: req.address, plen: req.prefix_len};
    end
    rd_entry <= table_mem[scan_idx[IDX_W-1:0]];
  end

  // Hold the queried address for the scan
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      query <= req.address;
    end
  end

  // Sequencer, entry count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      rsp       <= '0;
    end else begin
      // drop the response once it transfers, unless a new one loads
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_valid <= 1'b0;
          scan_idx <= '0;
          if (req_xfer) begin
            case (req.action)
              sml_pkg::ACT_CLEAR: begin
                count     <= '0;
                rsp_valid <= 1'b1;
                rsp       <= '{is_protected: 1'b0, accepted: 1'b1};
              end
              sml_pkg::ACT_APPEND: begin
                if (wr_en) begin
                  count <= count + CNT_W'(1);
                end
                rsp_valid <= 1'b1;
                rsp       <= '{is_protected: 1'b0, accepted: wr_en};
              end
              sml_pkg::ACT_LOOKUP: begin
                if (count == '0) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{is_protected: 1'b0, accepted: 1'b1};
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                rsp_valid <= 1'b1;
                rsp       <= '{is_protected: 1'b0, accepted: 1'b0};
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit || !issue) begin
            // first match, or last entry compared without one
            state     <= S_IDLE;
            rd_valid  <= 1'b0;
            rsp_valid <= 1'b1;
            rsp       <= '{is_protected: hit, accepted: 1'b1};
          end else begin
            // advance the read address
            scan_idx <= scan_idx + CNT_W'(1);
            rd_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/sml_check.sv]
// Port-level checks for subnet_membership_match, with the bind that attaches
// them. Uses sml_pkg types.
`default_nettype none

module sml_check (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire sml_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire sml_pkg::rsp_t rsp
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A hit is always an accepted lookup
  a_hit_accepted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_protected |-> rsp.accepted)
    else $error("protected response not accepted");

  // No request transfer while a response is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
    else $error("request taken over a blocked response");

  // After a request transfer, either a response shows or the block is busy
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid || req_stall)
    else $error("request transfer left no trace");

endmodule

bind subnet_membership_match sml_check u_sml_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

[dv/testbench.sv]
// Testbench for subnet_membership_match: directed and random clear, append and
// lookup transfers checked against an in-bench table model. Depends on sml_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RESET_CYCLES = 12;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    sml_pkg::req_t payload;
    bit            drain_first;
  } pending_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  sml_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  sml_pkg::rsp_t rsp;

  // Stimulus waiting to be sent and verdicts waiting to come back
  pending_t request_q[$];
  sml_pkg::rsp_t verdict_q[$];
  // Entries the stimulus has appended since the last clear, used to aim lookups
  sml_pkg::entry_t staged_entries[$];

  // Table model state
  logic [sml_pkg::ADDR_W-1:0] member_net [TABLE_DEPTH];
  logic [sml_pkg::PLEN_W-1:0] member_plen [TABLE_DEPTH];
  int unsigned member_count = 0;

  int unsigned total_items = 0;
  int unsigned requests_taken = 0;
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 0;
  bit req_fired = 1'b0;
  bit rsp_fired = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 3;
  bit send_burst = 1'b0;
  bit hold_burst = 1'b0;

  subnet_membership_match #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the table model and return the verdict it earns
  function automatic sml_pkg::rsp_t membership_verdict(sml_pkg::req_t r);
    sml_pkg::rsp_t verdict;
    logic [sml_pkg::ADDR_W-1:0] mask;
    logic [sml_pkg::PLEN_W-1:0] plen;
    verdict = '0;
    case (r.action)
      sml_pkg::ACT_CLEAR: begin
        member_count = 0;
        verdict.accepted = 1'b1;
      end
      sml_pkg::ACT_APPEND: begin
        if (member_count < TABLE_DEPTH) begin
          member_net[member_count] = r.address;
          member_plen[member_count] = r.prefix_len;
          member_count++;
          verdict.accepted = 1'b1;
        end
      end
      sml_pkg::ACT_LOOKUP: begin
        verdict.accepted = 1'b1;
        for (int unsigned i = 0; i < member_count; i++) begin
          plen = member_plen[i];
          // zero prefix means exact match; 32 and above use the full mask
          if (plen == 0) mask = '1;
          else if (plen >= 32) mask = '1;
          else mask = (32'd1 << plen) - 32'd1;
          if (((member_net[i] ^ r.address) & mask) == '0) begin
            verdict.is_protected = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    return verdict;
  endfunction

  // Queue one request, track appended entries and grow the run budget
  task automatic queue_request(input logic [1:0] act_code,
                               input logic [sml_pkg::ADDR_W-1:0] addr,
                               input logic [sml_pkg::PLEN_W-1:0] plen, input bit drain);
    pending_t item;
    item.payload.action = sml_pkg::action_t'(act_code);
    item.payload.address = addr;
    item.payload.prefix_len = plen;
    item.drain_first = drain;
    request_q.push_back(item);
    total_items++;
    cycle_limit += 2 * MAX_WAIT + 4;
    if (act_code == sml_pkg::ACT_LOOKUP) cycle_limit += staged_entries.size();
    if (act_code == sml_pkg::ACT_CLEAR) staged_entries.delete();
    else if (act_code == sml_pkg::ACT_APPEND && staged_entries.size() < TABLE_DEPTH)
      staged_entries.push_back({addr, plen});
  endtask

  // Build the stimulus, release reset, then wait for the last verdict
  initial begin : stimulus
    int unsigned pick;
    int unsigned sel;
    bit drain;
    logic [sml_pkg::PLEN_W-1:0] plen;
    logic [sml_pkg::ADDR_W-1:0] addr;
    logic [sml_pkg::ADDR_W-1:0] mask;
    sml_pkg::entry_t target;

    // Directed: empty table, unused code, every prefix class
    queue_request(sml_pkg::ACT_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
    queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'h0000_00AB, 6'd8, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hFFFF_FFAB, 6'd0, 1'b1);
    queue_request(sml_pkg::ACT_LOOKUP, 32'h0000_00AA, 6'd63, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'hDEAD_BEEF, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hDEAD_BEEF, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hDEAD_BEEE, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'h1234_5678, 6'd63, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'h1234_5678, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'h9234_5678, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'h0000_0001, 6'd1, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'h8000_0003, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_APPEND, 32'h7FFF_FFFE, 6'd31, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hFFFF_FFFE, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_CLEAR, 32'h0000_0000, 6'd0, 1'b0);
    queue_request(sml_pkg::ACT_LOOKUP, 32'hFFFF_FFAB, 6'd0, 1'b0);
    queue_request(ACT_UNUSED, 32'h0000_0000, 6'd0, 1'b0);

    // Random mix: mostly appends and aimed lookups on small tables
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 19) == 0);
      if (staged_entries.size() >= 40 || pick < 5) begin
        queue_request(sml_pkg::ACT_CLEAR, $urandom, 6'($urandom_range(0, 63)), drain);
      end else if (pick < 9) begin
        queue_request(ACT_UNUSED, $urandom, 6'($urandom_range(0, 63)), drain);
      end else if (pick < 50) begin
        sel = $urandom_range(0, 9);
        if (sel < 2) plen = 6'd0;
        else if (sel < 7) plen = 6'($urandom_range(1, 31));
        else if (sel < 8) plen = 6'd32;
        else plen = 6'($urandom_range(33, 63));
        queue_request(sml_pkg::ACT_APPEND, $urandom, plen, drain);
      end else begin
        addr = $urandom;
        if (staged_entries.size() > 0 && $urandom_range(0, 9) < 7) begin
          target = staged_entries[$urandom_range(0, staged_entries.size() - 1)];
          addr = target.net;
          case ($urandom_range(0, 2))
            // scramble the bits outside the compared prefix
            1: begin
              if (target.plen != 0 && target.plen < 32) begin
                mask = (32'd1 << target.plen) - 32'd1;
                addr = (addr & mask) | ($urandom & ~mask);
              end
            end
            // flip one bit inside the compared region
            2: begin
              if (target.plen == 0 || target.plen >= 32)
                addr = addr ^ (32'd1 << $urandom_range(0, 31));
              else
                addr = addr ^ (32'd1 << $urandom_range(0, target.plen - 1));
            end
            default: ;
          endcase
        end
        queue_request(sml_pkg::ACT_LOOKUP, addr, 6'($urandom_range(0, 63)), drain);
      end
    end

    cycle_limit = 4 * cycle_limit + RESET_CYCLES + 2000;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (requests_taken == total_items && verdict_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Present requests; hold a stalled transfer, pause between transfers
  always @(negedge clk) begin : request_driver
    pending_t next_item;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (request_q.size() > 0 &&
                   !(request_q[0].drain_first && verdict_q.size() > 0)) begin
        next_item = request_q.pop_front();
        req <= next_item.payload;
        req_valid <= 1'b1;
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Stall each response a drawn number of cycles; stall at random while idle
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_fired) begin
        if ($urandom_range(0, 19) == 0) hold_burst = !hold_burst;
        hold_left = hold_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (rsp_valid) begin
        rsp_stall <= (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Record transfers on both channels and check each verdict in order
  always @(posedge clk) begin : monitor
    sml_pkg::rsp_t want;
    req_fired = 1'b0;
    rsp_fired = 1'b0;
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("testbench failed");
      $finish;
    end else if (!rst) begin
      if (req_valid && !req_stall) begin
        req_fired = 1'b1;
        requests_taken++;
        verdict_q.push_back(membership_verdict(req));
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_fired = 1'b1;
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response: expected none, actual %b", $time, rsp);
        end else begin
          want = verdict_q.pop_front();
          if (rsp.is_protected !== want.is_protected) begin
            fail_count++;
            $display("%0t: is_protected mismatch: expected %0b, actual %0b",
                     $time, want.is_protected, rsp.is_protected);
          end
          if (rsp.accepted !== want.accepted) begin
            fail_count++;
            $display("%0t: accepted mismatch: expected %0b, actual %0b",
                     $time, want.accepted, rsp.accepted);
          end
        end
      end
    end
  end

endmodule

[subnet_membership_match.f]
rtl/sml_pkg.sv
rtl/subnet_membership_match.sv
rtl/sml_check.sv
dv/testbench.sv
